>>> src/gfb_pkg.sv
// Package for the gradient fill block: field widths, register indexes,
// style codes and the structs that pass between the front, queue and back.
// No dependencies.
package gfb_pkg;

    localparam int NCH        = 3;   // red, green, blue
    localparam int CH_W       = 16;  // width of one packed color channel
    localparam int PIX_W      = 8;   // width of one output channel
    localparam int POS_W      = 13;  // column / row width
    localparam int DIM_W      = 14;  // frame width / height register width
    localparam int COLOR_W    = NCH * CH_W;
    localparam int NUM_W      = POS_W + CH_W;  // |pos * diff|
    localparam int Q_W        = CH_W;          // quotient magnitude < 2**16
    localparam int STEPS      = 2;             // quotient bits per divider stage
    localparam int DIV_STAGES = Q_W / STEPS;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = COLOR_W;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_STYLE        = 3'd0;
    localparam cfg_idx_t CFG_FIRST_COLOR  = 3'd1;
    localparam cfg_idx_t CFG_SECOND_COLOR = 3'd2;
    localparam cfg_idx_t CFG_WIDTH        = 3'd3;
    localparam cfg_idx_t CFG_HEIGHT       = 3'd4;
    localparam cfg_idx_t CFG_BRIGHTNESS   = 3'd5;

    typedef logic [1:0] style_t;
    localparam style_t STYLE_SOLID = 2'd0;
    localparam style_t STYLE_HORIZ = 2'd1;
    localparam style_t STYLE_VERT  = 2'd2;

    // Classified pixel: solid fill travels as pos 0, ext 1.
    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [DIM_W-1:0] ext;
    } job_t;

    // Side data that rides along the divider.
    typedef struct packed {
        logic [NCH-1:0][CH_W-1:0] c1;
        logic [NCH-1:0]           neg;
    } tag_t;

endpackage

>>> src/gradient_fill_with_brightness.sv
// Top level of the gradient fill: configuration registers, front end,
// job queue and back end. Depends on gfb_pkg, gfb_front, gfb_queue, gfb_back.
//
// Usage:
//   Input channel s_valid/s_ready carries one pixel coordinate (s_column,
//   s_row) per transfer. Output channel m_valid/m_ready carries the 8-bit
//   color (m_red, m_green, m_blue) of that pixel, one transfer per input,
//   in input order.
//   Configuration: pulse cfg_wr_en with cfg_index and cfg_data; index 0 is
//   the style, 1 and 2 the packed 16-bit colors, 3 and 4 the frame width
//   and height, 5 the signed brightness. Indexes 6 and 7 are ignored.
//   Write configuration only while no pixel is in flight.
//   Throughput: one pixel per cycle while m_ready stays high.
//   Path: from input transfer to output transfer a pixel passes the front
//   register, the queue, the multiplier register, eight divider stages (two
//   quotient bits a stage) and the output register.
//   Stall: when m_ready is low while m_valid is high the back pipeline
//   holds; the front keeps taking pixels until the 4-entry queue and its own
//   register fill, then drops s_ready.
//   Reset (aresetn low, synchronous): clear all valids and empty the queue;
//   registers return to solid style, black colors, 1x1 frame, no offset.
module gradient_fill_with_brightness #(
    parameter int MAX_DIM     = 8192,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration write port
    input  logic                           cfg_wr_en,
    input  logic [gfb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gfb_pkg::CFG_DATA_W-1:0] cfg_data,
    // pixel coordinate in
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [gfb_pkg::POS_W-1:0]      s_column,
    input  logic [gfb_pkg::POS_W-1:0]      s_row,
    // pixel color out
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [gfb_pkg::PIX_W-1:0]      m_red,
    output logic [gfb_pkg::PIX_W-1:0]      m_green,
    output logic [gfb_pkg::PIX_W-1:0]      m_blue
);
    import gfb_pkg::*;

    style_t                   style_reg;
    logic [COLOR_W-1:0]       first_reg;
    logic [COLOR_W-1:0]       second_reg;
    logic [DIM_W-1:0]         width_reg;
    logic [DIM_W-1:0]         height_reg;
    logic signed [PIX_W-1:0]  bright_reg;

    logic                     fq_valid;
    logic                     fq_ready;
    job_t                     fq_job;
    logic                     qb_valid;
    logic                     qb_ready;
    job_t                     qb_job;

    // Configuration registers: take each write at once, drop unknown indexes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            style_reg  <= STYLE_SOLID;
            first_reg  <= '0;
            second_reg <= '0;
            width_reg  <= DIM_W'(1);
            height_reg <= DIM_W'(1);
            bright_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_STYLE:        style_reg  <= cfg_data[1:0];
                CFG_FIRST_COLOR:  first_reg  <= cfg_data[COLOR_W-1:0];
                CFG_SECOND_COLOR: second_reg <= cfg_data[COLOR_W-1:0];
                CFG_WIDTH:        width_reg  <= cfg_data[DIM_W-1:0];
                CFG_HEIGHT:       height_reg <= cfg_data[DIM_W-1:0];
                CFG_BRIGHTNESS:   bright_reg <= $signed(cfg_data[PIX_W-1:0]);
                default: begin
                end
            endcase
        end
    end

    // Front: accept a coordinate, pick position and extent for the style.
    gfb_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_column     (s_column),
        .s_row        (s_row),
        .fill_style   (style_reg),
        .frame_width  (width_reg),
        .frame_height (height_reg),
        .job_valid    (fq_valid),
        .job_ready    (fq_ready),
        .job          (fq_job)
    );

    // Queue: decouple front stalls from back stalls.
    gfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_job   (fq_job),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_job   (qb_job)
    );

    // Back: interpolate each channel, add brightness, clamp, present.
    gfb_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .job_valid    (qb_valid),
        .job_ready    (qb_ready),
        .job          (qb_job),
        .first_color  (first_reg),
        .second_color (second_reg),
        .brightness   (bright_reg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_red        (m_red),
        .m_green      (m_green),
        .m_blue       (m_blue)
    );

endmodule

>>> src/gfb_front.sv
// Front end of the gradient fill: accepts pixel coordinates and classifies
// them into (position, extent) jobs. Depends on gfb_pkg.
module gfb_front #(
    parameter int MAX_DIM = 8192
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [gfb_pkg::POS_W-1:0] s_column,
    input  logic [gfb_pkg::POS_W-1:0] s_row,
    input  gfb_pkg::style_t           fill_style,
    input  logic [gfb_pkg::DIM_W-1:0] frame_width,
    input  logic [gfb_pkg::DIM_W-1:0] frame_height,
    output logic                      job_valid,
    input  logic                      job_ready,
    output gfb_pkg::job_t             job
);
    import gfb_pkg::*;

    logic             vld_reg;
    logic             vld_next;
    job_t             job_reg;
    job_t             job_next;
    logic [DIM_W-1:0] ext_raw;
    logic [DIM_W-1:0] ext_sat;
    logic [POS_W-1:0] pos_raw;
    logic             take;

    assign s_ready   = !vld_reg || job_ready;
    assign take      = s_valid && s_ready;
    assign job_valid = vld_reg;
    assign job       = job_reg;

    always_comb begin
        pos_raw = '0;
        ext_raw = DIM_W'(1);
        case (fill_style)
            STYLE_HORIZ: begin
                pos_raw = s_column;
                ext_raw = frame_width;
            end
            STYLE_VERT: begin
                pos_raw = s_row;
                ext_raw = frame_height;
            end
            default: begin
                pos_raw = '0;
                ext_raw = DIM_W'(1);
            end
        endcase

        // Zero extent acts as one; clip to the largest supported dimension.
        ext_sat = ext_raw;
        if (ext_raw == '0) begin
            ext_sat = DIM_W'(1);
        end else if (32'(ext_raw) > MAX_DIM) begin
            ext_sat = DIM_W'(MAX_DIM);
        end

        job_next.ext = ext_sat;
        if ({1'b0, pos_raw} >= ext_sat) begin
            job_next.pos = POS_W'(ext_sat - DIM_W'(1));
        end else begin
            job_next.pos = pos_raw;
        end

        vld_next = vld_reg;
        if (take) begin
            vld_next = 1'b1;
        end else if (job_ready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            job_reg <= job_next;
        end
    end

endmodule

>>> src/gfb_queue.sv
// Short job queue between the front and back of the gradient fill.
// Depends on gfb_pkg.
module gfb_queue #(
    parameter int DEPTH = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  gfb_pkg::job_t wr_job,
    output logic          rd_valid,
    input  logic          rd_ready,
    output gfb_pkg::job_t rd_job
);
    import gfb_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_job   = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

>>> src/gfb_divider.sv
// Pipelined restoring divider for the three gradient channels, two
// quotient bits per stage, with side data carried alongside. Depends on gfb_pkg.
module gfb_divider (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   adv,
    input  logic                                   in_vld,
    input  logic [gfb_pkg::NCH-1:0][gfb_pkg::NUM_W-1:0] in_num,
    input  logic [gfb_pkg::DIM_W-1:0]              in_den,
    input  gfb_pkg::tag_t                          in_tag,
    output logic                                   out_vld,
    output logic [gfb_pkg::NCH-1:0][gfb_pkg::Q_W-1:0]   out_quo,
    output gfb_pkg::tag_t                          out_tag
);
    import gfb_pkg::*;

    logic                           vld_reg [DIV_STAGES];
    logic [NCH-1:0][DIM_W-1:0]      rem_reg [DIV_STAGES];
    logic [NCH-1:0][Q_W-1:0]        wrk_reg [DIV_STAGES];
    logic [DIM_W-1:0]               den_reg [DIV_STAGES];
    tag_t                           tag_reg [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        logic                      src_vld;
        logic [NCH-1:0][DIM_W-1:0] src_rem;
        logic [NCH-1:0][Q_W-1:0]   src_wrk;
        logic [DIM_W-1:0]          src_den;
        tag_t                      src_tag;
        logic [NCH-1:0][DIM_W-1:0] rem_next;
        logic [NCH-1:0][Q_W-1:0]   wrk_next;

        if (s == 0) begin : g_first
            always_comb begin
                src_vld = in_vld;
                src_den = in_den;
                src_tag = in_tag;
                for (int c = 0; c < NCH; c++) begin
                    // Upper dividend bits are already below the divisor.
                    src_rem[c] = DIM_W'(in_num[c][NUM_W-1:Q_W]);
                    src_wrk[c] = in_num[c][Q_W-1:0];
                end
            end
        end else begin : g_rest
            always_comb begin
                src_vld = vld_reg[s-1];
                src_rem = rem_reg[s-1];
                src_wrk = wrk_reg[s-1];
                src_den = den_reg[s-1];
                src_tag = tag_reg[s-1];
            end
        end

        always_comb begin
            logic [DIM_W:0]   trial;
            logic [DIM_W-1:0] r;
            logic [Q_W-1:0]   w;
            logic             bit_q;
            for (int c = 0; c < NCH; c++) begin
                r = src_rem[c];
                w = src_wrk[c];
                for (int j = 0; j < STEPS; j++) begin
                    trial = {r, w[Q_W-1]};
                    bit_q = (trial >= {1'b0, src_den});
                    if (bit_q) begin
                        r = DIM_W'(trial - {1'b0, src_den});
                    end else begin
                        r = trial[DIM_W-1:0];
                    end
                    w = {w[Q_W-2:0], bit_q};
                end
                rem_next[c] = r;
                wrk_next[c] = w;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (adv) begin
                vld_reg[s] <= src_vld;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[s] <= rem_next;
                wrk_reg[s] <= wrk_next;
                den_reg[s] <= src_den;
                tag_reg[s] <= src_tag;
            end
        end
    end

    assign out_vld = vld_reg[DIV_STAGES-1];
    assign out_quo = wrk_reg[DIV_STAGES-1];
    assign out_tag = tag_reg[DIV_STAGES-1];

endmodule

>>> src/gfb_back.sv
// Back end of the gradient fill: multiply, divide, brightness and clamp,
// ending in the output register. Depends on gfb_pkg and gfb_divider.
module gfb_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         job_valid,
    output logic                         job_ready,
    input  gfb_pkg::job_t                job,
    input  logic [gfb_pkg::COLOR_W-1:0]  first_color,
    input  logic [gfb_pkg::COLOR_W-1:0]  second_color,
    input  logic signed [gfb_pkg::PIX_W-1:0] brightness,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [gfb_pkg::PIX_W-1:0]    m_red,
    output logic [gfb_pkg::PIX_W-1:0]    m_green,
    output logic [gfb_pkg::PIX_W-1:0]    m_blue
);
    import gfb_pkg::*;

    logic                     adv;
    logic                     pop;

    // multiply stage
    logic                     mul_vld_reg;
    logic [NCH-1:0][NUM_W-1:0] mul_num_reg;
    logic [NCH-1:0][NUM_W-1:0] mul_num_next;
    logic [DIM_W-1:0]         mul_den_reg;
    tag_t                     mul_tag_reg;
    tag_t                     mul_tag_next;

    // divider outputs
    logic                     div_vld;
    logic [NCH-1:0][Q_W-1:0]  div_quo;
    tag_t                     div_tag;

    // output stage
    logic                     out_vld_reg;
    logic [NCH-1:0][PIX_W-1:0] pix_reg;
    logic [NCH-1:0][PIX_W-1:0] pix_next;

    // The whole back pipeline moves together whenever the output is free.
    assign adv       = !out_vld_reg || m_ready;
    assign job_ready = adv;
    assign pop       = job_valid && adv;

    always_comb begin
        logic [CH_W-1:0]       c1;
        logic [CH_W-1:0]       c2;
        logic signed [CH_W:0]  diff;
        logic [CH_W-1:0]       mag;
        for (int c = 0; c < NCH; c++) begin
            // red sits in the top 16 bits
            c1   = first_color[(NCH-1-c)*CH_W +: CH_W];
            c2   = second_color[(NCH-1-c)*CH_W +: CH_W];
            diff = $signed({1'b0, c2}) - $signed({1'b0, c1});
            mag  = diff[CH_W] ? CH_W'(-diff) : diff[CH_W-1:0];
            mul_num_next[c]     = NUM_W'(job.pos) * NUM_W'(mag);
            mul_tag_next.c1[c]  = c1;
            mul_tag_next.neg[c] = diff[CH_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_vld_reg <= 1'b0;
        end else if (adv) begin
            mul_vld_reg <= pop;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mul_num_reg <= mul_num_next;
            mul_den_reg <= job.ext;
            mul_tag_reg <= mul_tag_next;
        end
    end

    gfb_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .in_vld  (mul_vld_reg),
        .in_num  (mul_num_reg),
        .in_den  (mul_den_reg),
        .in_tag  (mul_tag_reg),
        .out_vld (div_vld),
        .out_quo (div_quo),
        .out_tag (div_tag)
    );

    always_comb begin
        logic signed [CH_W+1:0]  q_s;
        logic signed [CH_W+1:0]  v;
        logic [PIX_W-1:0]        hi;
        logic signed [PIX_W+1:0] sum;
        for (int c = 0; c < NCH; c++) begin
            q_s = $signed({2'b00, div_quo[c]});
            if (div_tag.neg[c]) begin
                q_s = -q_s;
            end
            v = $signed({2'b00, div_tag.c1[c]}) + q_s;
            if (v < 0) begin
                hi = '0;
            end else if (v > $signed((CH_W+2)'(16'hffff))) begin
                hi = '1;
            end else begin
                hi = v[CH_W-1:PIX_W];
            end
            sum = $signed({2'b00, hi}) + (PIX_W+2)'(brightness);
            if (sum < 0) begin
                pix_next[c] = '0;
            end else if (sum > $signed((PIX_W+2)'(255))) begin
                pix_next[c] = '1;
            end else begin
                pix_next[c] = sum[PIX_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            out_vld_reg <= div_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pix_reg <= pix_next;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_red   = pix_reg[0];
    assign m_green = pix_reg[1];
    assign m_blue  = pix_reg[2];

endmodule
